/* design/almm_pkg.sv */
// almm_pkg: widths, register codes, control structs and the shared run-counter
// update for the adaptive low-pass motion magnitude block
// no dependencies
package almm_pkg;

  // sample width
  localparam int SAMPLE_BITS = 16;
  localparam int NUM_AXES    = 3;

  // axis datapath widths
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int COEF_W      = 8;
  localparam int FRAC_W      = 8;
  localparam int CNT_W       = 7;
  localparam int CNT_SUM_W   = CNT_W + 1;
  localparam int THR_W       = 16;
  localparam int JCMP_W      = (DIFF_W > THR_W) ? DIFF_W : THR_W;
  localparam int AXIS_PROD_W = DIFF_W + COEF_W + 1;

  // magnitude datapath widths
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int ITER_W      = $clog2(ROOT_W);
  localparam int MAG_W       = 8;
  localparam int MAG_DIFF_W  = MAG_W + 1;
  localparam int MAG_SUM_W   = MAG_W + 2;
  localparam int MAG_PROD_W  = MAG_DIFF_W + COEF_W + 1;

  // fixed run-counter constants
  localparam logic [CNT_SUM_W-1:0]  RUN_STEP      = CNT_SUM_W'(5);
  localparam logic [MAG_DIFF_W-1:0] MAG_JUMP_DIFF = MAG_DIFF_W'(30);
  localparam logic [CNT_W-1:0]      MAG_RUN_LIMIT = CNT_W'(50);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_COEF_BASE  = 3'd0,
    CFG_AXIS_COEF_STEP  = 3'd1,
    CFG_AXIS_JUMP_THR   = 3'd2,
    CFG_AXIS_RUN_LIMIT  = 3'd3,
    CFG_MAG_COEF_BASE   = 3'd4,
    CFG_MAG_COEF_STEP   = 3'd5,
    CFG_MAG_UPPER_CLAMP = 3'd6,
    CFG_MAG_FLOOR_CUT   = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [COEF_W-1:0] RST_AXIS_COEF_BASE  = COEF_W'(30);
  localparam logic [COEF_W-1:0] RST_AXIS_COEF_STEP  = COEF_W'(5);
  localparam logic [THR_W-1:0]  RST_AXIS_JUMP_THR   = THR_W'(300);
  localparam logic [CNT_W-1:0]  RST_AXIS_RUN_LIMIT  = CNT_W'(30);
  localparam logic [COEF_W-1:0] RST_MAG_COEF_BASE   = COEF_W'(80);
  localparam logic [COEF_W-1:0] RST_MAG_COEF_STEP   = COEF_W'(20);
  localparam logic [MAG_W-1:0]  RST_MAG_UPPER_CLAMP = MAG_W'(200);
  localparam logic [MAG_W-1:0]  RST_MAG_FLOOR_CUT   = MAG_W'(5);

  typedef struct packed {
    logic [COEF_W-1:0] coef_base;
    logic [COEF_W-1:0] coef_step;
    logic [THR_W-1:0]  jump_thr;
    logic [CNT_W-1:0]  run_limit;
  } axis_cfg_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_base;
    logic [COEF_W-1:0] coef_step;
    logic [MAG_W-1:0]  upper_clamp;
    logic [MAG_W-1:0]  floor_cut;
  } mag_cfg_t;

  typedef struct packed {
    logic adapt;
    logic scale;
    logic square;
  } lane_ctl_t;

  typedef struct packed {
    logic adapt;
    logic scale;
  } mag_ctl_t;

  typedef struct packed {
    logic              flag;
    logic [CNT_W-1:0]  cnt;
    logic [COEF_W-1:0] coef;
  } run_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADAPT,
    ST_SCALE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_MAG_ADAPT,
    ST_MAG_SCALE,
    ST_DONE
  } state_e;

  // direction-run tracking shared by the axis lanes and the magnitude filter
  function automatic run_state_t adapt_run(run_state_t cur, logic rise, logic jump,
                                           logic [CNT_W-1:0] limit,
                                           logic [COEF_W-1:0] base,
                                           logic [COEF_W-1:0] step);
    run_state_t nxt;
    logic [CNT_SUM_W-1:0] cnt_sum;
    nxt = cur;
    cnt_sum = {1'b0, cur.cnt} + CNT_SUM_W'(1) + (jump ? RUN_STEP : '0);
    if (rise == cur.flag) begin
      if (cnt_sum > {1'b0, limit}) begin
        nxt.coef = cur.coef + step;
        nxt.cnt  = '0;
      end else begin
        nxt.cnt = cnt_sum[CNT_W-1:0];
      end
    end else begin
      nxt.cnt  = '0;
      nxt.coef = base;
    end
    nxt.flag = rise;
    return nxt;
  endfunction

endpackage

/* design/almm_if.sv */
// almm channel interfaces: sample input, result output and register write
// depends on almm_pkg
interface almm_sample_if import almm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  modport source(output valid, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface almm_result_if import almm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smooth_x;
  logic signed [SAMPLE_BITS-1:0] smooth_y;
  logic signed [SAMPLE_BITS-1:0] smooth_z;
  logic [MAG_W-1:0]              motion_magnitude;
  modport source(output valid, smooth_x, smooth_y, smooth_z, motion_magnitude,
                 input ready);
  modport sink(input valid, smooth_x, smooth_y, smooth_z, motion_magnitude,
               output ready);
endinterface

interface almm_cfg_if import almm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source(output valid, index, wdata, input ready);
  modport sink(input valid, index, wdata, output ready);
endinterface

/* design/almm_axis_lane.sv */
// almm_axis_lane: one axis of adaptive low-pass filtering plus the squared change
// depends on almm_pkg
module almm_axis_lane import almm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctl_t                     ctl_i,
  input  axis_cfg_t                     cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] smooth_o,
  output logic [SQ_W-1:0]               sq_o
);

  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  run_state_t                    run_q, run_d;
  logic signed [DIFF_W-1:0]      diff_q, diff_d;
  logic signed [DIFF_W-1:0]      chg_q;
  logic [SQ_W-1:0]               sq_q;

  logic                          rise;
  logic [DIFF_W-1:0]             abs_diff;
  logic                          jump;
  logic signed [AXIS_PROD_W-1:0] prod;
  logic signed [AXIS_PROD_W-1:0] biased;
  logic signed [DIFF_W-1:0]      quo;
  logic [DIFF_W-1:0]             new_val;
  logic [DIFF_W-1:0]             abs_chg;
  logic [SAMPLE_BITS-1:0]        chg_mag;

  // direction tracking
  always_comb begin
    diff_d   = {sample_i[SAMPLE_BITS-1], sample_i} - {prev_q[SAMPLE_BITS-1], prev_q};
    rise     = !diff_d[DIFF_W-1] && (diff_d != '0);
    abs_diff = diff_d[DIFF_W-1] ? (~diff_d + 1'b1) : diff_d;
    jump     = JCMP_W'(abs_diff) > JCMP_W'(cfg_i.jump_thr);
    run_d    = adapt_run(run_q, rise, jump, cfg_i.run_limit, cfg_i.coef_base,
                         cfg_i.coef_step);
  end

  // scaled step, division by 256 rounds toward zero
  always_comb begin
    prod    = diff_q * $signed({1'b0, run_q.coef});
    biased  = prod + $signed({{(AXIS_PROD_W-FRAC_W){1'b0}},
                              {FRAC_W{prod[AXIS_PROD_W-1]}}});
    quo     = biased[DIFF_W+FRAC_W-1:FRAC_W];
    new_val = {prev_q[SAMPLE_BITS-1], prev_q} + quo;
    prev_d  = new_val[SAMPLE_BITS-1:0];
    abs_chg = chg_q[DIFF_W-1] ? (~chg_q + 1'b1) : chg_q;
    chg_mag = abs_chg[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      run_q  <= '0;
    end else begin
      if (ctl_i.adapt) run_q <= run_d;
      if (ctl_i.scale) prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adapt)  diff_q <= diff_d;
    if (ctl_i.scale)  chg_q  <= quo;
    if (ctl_i.square) sq_q   <= SQ_W'(chg_mag) * SQ_W'(chg_mag);
  end

  assign smooth_o = prev_q;
  assign sq_o     = sq_q;

endmodule

/* design/almm_isqrt.sv */
// almm_isqrt: restoring floor square root, one root bit per cycle
// depends on almm_pkg
module almm_isqrt import almm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W-1:SUM_W-2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ITER_W'(ROOT_W - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/almm_mag_filter.sv */
// almm_mag_filter: clamp, adaptive low-pass and floor cut of the raw magnitude
// depends on almm_pkg
module almm_mag_filter import almm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mag_ctl_t          ctl_i,
  input  mag_cfg_t          cfg_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [MAG_W-1:0]  mag_o
);

  logic [MAG_W-1:0]             prev_q, prev_d;
  run_state_t                   run_q, run_d;
  logic signed [MAG_DIFF_W-1:0] diff_q, diff_d;

  logic [MAG_W-1:0]             raw;
  logic                         rise;
  logic [MAG_DIFF_W-1:0]        abs_diff;
  logic                         jump;
  logic signed [MAG_PROD_W-1:0] prod;
  logic signed [MAG_PROD_W-1:0] biased;
  logic signed [MAG_DIFF_W-1:0] quo;
  logic [MAG_SUM_W-1:0]         new_val;

  always_comb begin
    raw      = (root_i > ROOT_W'(cfg_i.upper_clamp)) ? cfg_i.upper_clamp
                                                     : root_i[MAG_W-1:0];
    diff_d   = {1'b0, raw} - {1'b0, prev_q};
    rise     = !diff_d[MAG_DIFF_W-1] && (diff_d != '0);
    abs_diff = diff_d[MAG_DIFF_W-1] ? (~diff_d + 1'b1) : diff_d;
    jump     = abs_diff > MAG_JUMP_DIFF;
    if (diff_d == '0) begin
      // no change: restart the run, keep the direction
      run_d      = run_q;
      run_d.cnt  = '0;
      run_d.coef = cfg_i.coef_base;
    end else begin
      run_d = adapt_run(run_q, rise, jump, MAG_RUN_LIMIT, cfg_i.coef_base,
                        cfg_i.coef_step);
    end
  end

  always_comb begin
    prod    = diff_q * $signed({1'b0, run_q.coef});
    biased  = prod + $signed({{(MAG_PROD_W-FRAC_W){1'b0}},
                              {FRAC_W{prod[MAG_PROD_W-1]}}});
    quo     = biased[MAG_DIFF_W+FRAC_W-1:FRAC_W];
    new_val = {2'b00, prev_q} + {quo[MAG_DIFF_W-1], quo};
    prev_d  = (new_val[MAG_W-1:0] < cfg_i.floor_cut) ? '0 : new_val[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      run_q  <= '0;
    end else begin
      if (ctl_i.adapt) run_q <= run_d;
      if (ctl_i.scale) prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adapt) diff_q <= diff_d;
  end

  assign mag_o = prev_q;

endmodule

/* design/adaptive_lowpass_motion_magnitude.sv */
// adaptive_lowpass_motion_magnitude: top level, sequencer, registers, output beat
// depends on almm_pkg, almm_if, almm_axis_lane, almm_isqrt, almm_mag_filter
// sequence: an accepted sample beat steps through adapt, scale, square, sum, the
// bit-serial square root, magnitude adapt and magnitude scale; one sample at a time
// the result sits in an output register, so a new sample is taken while it waits
// reset: filter state, run counters and coefficients clear, registers take defaults
module adaptive_lowpass_motion_magnitude import almm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  almm_sample_if.sink          sample_i,
  almm_result_if.source        result_o,
  almm_cfg_if.sink             cfg_i
);

  // configuration registers
  axis_cfg_t axis_cfg_q;
  mag_cfg_t  mag_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_cfg_q.coef_base <= RST_AXIS_COEF_BASE;
      axis_cfg_q.coef_step <= RST_AXIS_COEF_STEP;
      axis_cfg_q.jump_thr  <= RST_AXIS_JUMP_THR;
      axis_cfg_q.run_limit <= RST_AXIS_RUN_LIMIT;
      mag_cfg_q.coef_base   <= RST_MAG_COEF_BASE;
      mag_cfg_q.coef_step   <= RST_MAG_COEF_STEP;
      mag_cfg_q.upper_clamp <= RST_MAG_UPPER_CLAMP;
      mag_cfg_q.floor_cut   <= RST_MAG_FLOOR_CUT;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_AXIS_COEF_BASE:  axis_cfg_q.coef_base   <= cfg_i.wdata[COEF_W-1:0];
        CFG_AXIS_COEF_STEP:  axis_cfg_q.coef_step   <= cfg_i.wdata[COEF_W-1:0];
        CFG_AXIS_JUMP_THR:   axis_cfg_q.jump_thr    <= cfg_i.wdata[THR_W-1:0];
        CFG_AXIS_RUN_LIMIT:  axis_cfg_q.run_limit   <= cfg_i.wdata[CNT_W-1:0];
        CFG_MAG_COEF_BASE:   mag_cfg_q.coef_base    <= cfg_i.wdata[COEF_W-1:0];
        CFG_MAG_COEF_STEP:   mag_cfg_q.coef_step    <= cfg_i.wdata[COEF_W-1:0];
        CFG_MAG_UPPER_CLAMP: mag_cfg_q.upper_clamp  <= cfg_i.wdata[MAG_W-1:0];
        CFG_MAG_FLOOR_CUT:   mag_cfg_q.floor_cut    <= cfg_i.wdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // register writes complete at once
  assign cfg_i.ready = 1'b1;

  // sequencer
  state_e state_q, state_d;
  logic   in_beat;
  logic   root_done;
  logic   out_load;
  logic   root_start;
  lane_ctl_t lane_ctl;
  mag_ctl_t  mag_ctl;
  logic   out_valid_q, out_valid_d;

  assign in_beat = sample_i.valid && sample_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_beat) state_d = ST_ADAPT;
      ST_ADAPT:     state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_SUM;
      ST_SUM:       state_d = ST_ROOT;
      ST_ROOT:      if (root_done) state_d = ST_MAG_ADAPT;
      ST_MAG_ADAPT: state_d = ST_MAG_SCALE;
      ST_MAG_SCALE: state_d = ST_DONE;
      ST_DONE:      if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready  = (state_q == ST_IDLE);
    lane_ctl.adapt  = (state_q == ST_ADAPT);
    lane_ctl.scale  = (state_q == ST_SCALE);
    lane_ctl.square = (state_q == ST_SQUARE);
    root_start      = (state_q == ST_SUM);
    mag_ctl.adapt   = (state_q == ST_MAG_ADAPT);
    mag_ctl.scale   = (state_q == ST_MAG_SCALE);
    // result moves to the output register once the previous beat is gone
    out_load        = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // captured sample, one entry per axis
  logic signed [SAMPLE_BITS-1:0] sample_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q[0] <= sample_i.accel_x;
      sample_q[1] <= sample_i.accel_y;
      sample_q[2] <= sample_i.accel_z;
    end
  end

  // axis lanes run side by side
  logic signed [SAMPLE_BITS-1:0] smooth [NUM_AXES];
  logic [SQ_W-1:0]               sq     [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    almm_axis_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .cfg_i    (axis_cfg_q),
      .sample_i (sample_q[a]),
      .smooth_o (smooth[a]),
      .sq_o     (sq[a])
    );
  end

  // merge: exact sum of squared changes into the root unit
  logic [SUM_W-1:0]  sum_sq;
  logic [ROOT_W-1:0] root;
  logic [MAG_W-1:0]  mag;

  assign sum_sq = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

  almm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_sq),
    .done_o     (root_done),
    .root_o     (root)
  );

  almm_mag_filter u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mag_ctl),
    .cfg_i  (mag_cfg_q),
    .root_i (root),
    .mag_o  (mag)
  );

  // output register
  logic signed [SAMPLE_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [MAG_W-1:0]              out_mag_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q   <= smooth[0];
      out_y_q   <= smooth[1];
      out_z_q   <= smooth[2];
      out_mag_q <= mag;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.smooth_x         = out_x_q;
  assign result_o.smooth_y         = out_y_q;
  assign result_o.smooth_z         = out_z_q;
  assign result_o.motion_magnitude = out_mag_q;

endmodule

/* design/almm_checker.sv */
// almm_checker: port-level assertions for the motion magnitude block, plus its bind
// depends on almm_pkg and adaptive_lowpass_motion_magnitude
module almm_checker import almm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_x,
  input logic [SAMPLE_BITS-1:0] out_y,
  input logic [SAMPLE_BITS-1:0] out_z,
  input logic [MAG_W-1:0]       out_mag
);

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_x, out_y, out_z, out_mag}))
    else $error("result payload changed while stalled");

  // one sample at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while another is in flight");

  // no result appears right after a sample beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result beat too early");

endmodule

bind adaptive_lowpass_motion_magnitude almm_checker u_almm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_x     (result_o.smooth_x),
  .out_y     (result_o.smooth_y),
  .out_z     (result_o.smooth_z),
  .out_mag   (result_o.motion_magnitude)
);
